// File: hdl/gbds_pkg.sv
// Package for the grid path search block.
// Holds label, status, command, direction and register index codes shared by all files.
package gbds_pkg;
   localparam int GRID_SIDE_DEF = 64;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 6;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_BEGIN = 2'd1,
      CMD_STEP  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   localparam logic [2:0] LBL_SPACE    = 3'd0;
   localparam logic [2:0] LBL_WALL     = 3'd1;
   localparam logic [2:0] LBL_START    = 3'd2;
   localparam logic [2:0] LBL_TARGET   = 3'd3;
   localparam logic [2:0] LBL_VISITED  = 3'd4;
   localparam logic [2:0] LBL_FRONTIER = 3'd5;
   localparam logic [2:0] LBL_PATH     = 3'd6;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EXPANDED = 3'd1;
   localparam logic [2:0] ST_FOUND    = 3'd2;
   localparam logic [2:0] ST_NOPATH   = 3'd3;
   localparam logic [2:0] ST_IDLE     = 3'd4;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   localparam logic [2:0] REG_MODE  = 3'd0;
   localparam logic [2:0] REG_SROW  = 3'd1;
   localparam logic [2:0] REG_SCOL  = 3'd2;
   localparam logic [2:0] REG_TROW  = 3'd3;
   localparam logic [2:0] REG_TCOL  = 3'd4;
endpackage

// File: hdl/gbds_cfg.sv
// Configuration register file of the grid path search block.
// Depends on gbds_pkg for register indexes.
module gbds_cfg
   import gbds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  mode,
   output logic [5:0]            srow,
   output logic [5:0]            scol,
   output logic [5:0]            trow,
   output logic [5:0]            tcol
);
   logic       mode_ff;
   logic [5:0] srow_ff, scol_ff, trow_ff, tcol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         srow_ff <= 6'd32;
         scol_ff <= 6'd32;
         trow_ff <= 6'd0;
         tcol_ff <= 6'd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MODE: mode_ff <= csr_wdata[0];
            REG_SROW: srow_ff <= csr_wdata;
            REG_SCOL: scol_ff <= csr_wdata;
            REG_TROW: trow_ff <= csr_wdata;
            REG_TCOL: tcol_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign mode = mode_ff;
   assign srow = srow_ff;
   assign scol = scol_ff;
   assign trow = trow_ff;
   assign tcol = tcol_ff;
endmodule

// File: hdl/grid_bfs_dfs_path_search_top.sv
// Grid path search top level: label, parent and frontier memories with a sequencer.
// Depends on gbds_pkg and gbds_cfg.
//
// Usage: the req_ channel carries one command (write, begin, step, read) and
// the rsp_ channel returns exactly one result per command, in order.
// The csr_ port writes mode, start and target; write it only while idle.
// One command is in work at a time. An expanding step reads the label of
// each on-grid neighbour in turn and skips the off-grid ones. A new command
// can be taken in the cycle after the transfer.
// On finding the target, the path walk reads the parent and label of each
// cell of the path, at most GRID_SIDE*GRID_SIDE cells.
// After reset a clearing pass writes every label to space; req_ready stays
// low during it.
// The result sits in an output register; while the receiver stalls the
// block holds it and takes no new command.
module grid_bfs_dfs_path_search_top
   import gbds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_command,
   input  logic [5:0]            req_cell_row,
   input  logic [5:0]            req_cell_col,
   input  logic                  req_is_wall,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [5:0]            rsp_out_row,
   output logic [5:0]            rsp_out_col,
   output logic [2:0]            rsp_cell_label,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int GRID_SIDE = GRID_SIDE_DEF;
   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int SW    = $clog2(GRID_SIDE);
   localparam int AW    = 2 * SW;
   localparam int CW    = AW + 1;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_RDWAIT, S_RDDONE, S_BTGT, S_BSTART,
      S_FRD, S_FWAIT, S_CUR, S_CURW, S_NRD, S_NWAIT, S_NCHK,
      S_PRD, S_PWAIT, S_PCHK, S_RESP
   } state_type;

   state_type state_ff;
   logic       mode;
   logic [5:0] srow, scol, trow, tcol;

   gbds_cfg u_cfg (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .mode, .srow, .scol, .trow, .tcol
   );

   logic [2:0]    lbl_mem [CELLS];
   logic [1:0]    par_mem [CELLS];
   logic [AW-1:0] fr_mem  [CELLS];

   logic [AW-1:0] clr_ff;
   logic [AW-1:0] head_ff;
   logic [CW-1:0] cnt_ff;
   logic          run_ff;
   logic [1:0]    cmd_ff;
   logic [5:0]    row_ff, col_ff;
   logic          wall_ff;
   logic [SW-1:0] cr_ff, cc_ff;
   logic [SW-1:0] nr_ff, nc_ff;
   logic [1:0]    nb_ff;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] walk_ff;
   logic [2:0]    lrd_ff;
   logic [1:0]    prd_ff;
   logic [AW-1:0] frd_ff;
   logic [2:0]    st_ff;
   logic [5:0]    orow_ff, ocol_ff;
   logic [2:0]    olbl_ff;
   logic          rv_ff;

   logic          lw_en, pw_en, fw_en;
   logic [AW-1:0] lw_a, fw_a;
   logic [2:0]    lw_d;
   logic [AW-1:0] fr_ra;

   logic [AW-1:0] req_addr, start_addr, targ_addr, cur_addr;
   logic          nb_on;
   logic [SW-1:0] nbr, nbc;
   logic [1:0]    nb_back;

   assign req_addr   = {req_cell_row[SW-1:0], req_cell_col[SW-1:0]};
   assign start_addr = {srow[SW-1:0], scol[SW-1:0]};
   assign targ_addr  = {trow[SW-1:0], tcol[SW-1:0]};
   assign cur_addr   = {cr_ff, cc_ff};

   always_comb begin
      nb_on   = 1'b1;
      nbr     = cr_ff;
      nbc     = cc_ff;
      nb_back = DIR_UP;
      unique case (nb_ff)
         2'd0: begin
            nb_on = 32'(cr_ff) + 1 < GRID_SIDE;
            nbr = cr_ff + SW'(1);
            nb_back = DIR_UP;
         end
         2'd1: begin
            nb_on = cr_ff != '0;
            nbr = cr_ff - SW'(1);
            nb_back = DIR_DOWN;
         end
         2'd2: begin
            nb_on = 32'(cc_ff) + 1 < GRID_SIDE;
            nbc = cc_ff + SW'(1);
            nb_back = DIR_LEFT;
         end
         default: begin
            nb_on = cc_ff != '0;
            nbc = cc_ff - SW'(1);
            nb_back = DIR_RIGHT;
         end
      endcase
   end

   assign fr_ra = mode ? AW'(head_ff + cnt_ff[AW-1:0] - AW'(1)) : head_ff;

   always_comb begin
      lw_en = 1'b0; lw_a = addr_ff; lw_d = LBL_SPACE;
      pw_en = 1'b0; fw_en = 1'b0; fw_a = AW'(head_ff + cnt_ff[AW-1:0]);
      unique case (state_ff)
         S_CLEAR: begin
            lw_en = 1'b1; lw_a = clr_ff;
         end
         S_IDLE: begin
            lw_en = 1'b0;
         end
         S_RDDONE: begin
            lw_en = cmd_ff == CMD_WRITE && 32'(row_ff) < GRID_SIDE
                    && 32'(col_ff) < GRID_SIDE;
            lw_a = addr_ff; lw_d = wall_ff ? LBL_WALL : LBL_SPACE;
         end
         S_BTGT: begin
            lw_en = 32'(trow) < GRID_SIDE && 32'(tcol) < GRID_SIDE;
            lw_a = targ_addr; lw_d = LBL_TARGET;
         end
         S_BSTART: begin
            lw_en = 32'(srow) < GRID_SIDE && 32'(scol) < GRID_SIDE;
            lw_a = start_addr; lw_d = LBL_START;
            fw_en = lw_en; fw_a = '0;
         end
         S_CURW: begin
            lw_en = lrd_ff != LBL_START; lw_a = cur_addr; lw_d = LBL_VISITED;
         end
         S_NCHK: begin
            lw_en = lrd_ff == LBL_SPACE && 32'(cnt_ff) < CELLS;
            lw_a = addr_ff; lw_d = LBL_FRONTIER;
            pw_en = lw_en; fw_en = lw_en;
         end
         S_PCHK: begin
            lw_en = lrd_ff != LBL_START; lw_a = addr_ff; lw_d = LBL_PATH;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (lw_en) lbl_mem[lw_a] <= lw_d;
      if (pw_en) par_mem[addr_ff] <= nb_back;
      if (fw_en) fr_mem[fw_a] <= (state_ff == S_BSTART) ? start_addr : addr_ff;
      lrd_ff <= lbl_mem[addr_ff];
      prd_ff <= par_mem[addr_ff];
      frd_ff <= fr_mem[fr_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         head_ff  <= '0;
         cnt_ff   <= '0;
         run_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (32'(clr_ff) == CELLS - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff <= req_command; row_ff <= req_cell_row;
                  col_ff <= req_cell_col; wall_ff <= req_is_wall;
                  addr_ff <= req_addr;
                  st_ff <= ST_OK; orow_ff <= '0; ocol_ff <= '0; olbl_ff <= '0;
                  unique case (cmd_type'(req_command))
                     CMD_WRITE: state_ff <= S_RDDONE;
                     CMD_BEGIN: state_ff <= S_BTGT;
                     CMD_STEP: begin
                        if (!run_ff) begin
                           st_ff <= ST_IDLE; state_ff <= S_RESP;
                        end else if (cnt_ff == '0) begin
                           st_ff <= ST_NOPATH; run_ff <= 1'b0; state_ff <= S_RESP;
                        end else state_ff <= S_FRD;
                     end
                     default: state_ff <= S_RDWAIT;
                  endcase
               end
            end
            S_RDWAIT: state_ff <= S_RDDONE;
            S_RDDONE: begin
               if (cmd_ff != CMD_WRITE) begin
                  orow_ff <= row_ff; ocol_ff <= col_ff;
                  olbl_ff <= (32'(row_ff) < GRID_SIDE && 32'(col_ff) < GRID_SIDE)
                             ? lrd_ff : LBL_WALL;
               end
               state_ff <= S_RESP;
            end
            S_BTGT: begin
               head_ff <= '0; cnt_ff <= '0; run_ff <= 1'b0;
               state_ff <= S_BSTART;
            end
            S_BSTART: begin
               if (32'(srow) < GRID_SIDE && 32'(scol) < GRID_SIDE) begin
                  cnt_ff <= CW'(1); run_ff <= 1'b1;
               end
               state_ff <= S_RESP;
            end
            S_FRD: state_ff <= S_FWAIT;
            S_FWAIT: begin
               {cr_ff, cc_ff} <= frd_ff;
               addr_ff <= frd_ff;
               if (!mode) head_ff <= head_ff + AW'(1);
               cnt_ff <= cnt_ff - CW'(1);
               state_ff <= S_CUR;
            end
            S_CUR: state_ff <= S_CURW;
            S_CURW: begin
               orow_ff <= 6'(cr_ff); ocol_ff <= 6'(cc_ff);
               st_ff <= ST_EXPANDED;
               nb_ff <= 2'd0;
               state_ff <= S_NRD;
            end
            S_NRD: begin
               if (nb_on) begin
                  addr_ff <= {nbr, nbc}; state_ff <= S_NWAIT;
               end else if (nb_ff == 2'd3) state_ff <= S_RESP;
               else nb_ff <= nb_ff + 2'd1;
            end
            S_NWAIT: state_ff <= S_NCHK;
            S_NCHK: begin
               if (lrd_ff == LBL_TARGET) begin
                  run_ff <= 1'b0; st_ff <= ST_FOUND;
                  addr_ff <= cur_addr; walk_ff <= '0; state_ff <= S_PRD;
               end else begin
                  if (lw_en) cnt_ff <= cnt_ff + CW'(1);
                  if (nb_ff == 2'd3) state_ff <= S_RESP;
                  else begin
                     nb_ff <= nb_ff + 2'd1; state_ff <= S_NRD;
                  end
               end
            end
            S_PRD: state_ff <= S_PWAIT;
            S_PWAIT: state_ff <= S_PCHK;
            S_PCHK: begin
               if (lrd_ff == LBL_START) state_ff <= S_RESP;
               else if (32'(walk_ff) == CELLS - 1) state_ff <= S_RESP;
               else begin
                  walk_ff <= walk_ff + AW'(1);
                  unique case (prd_ff)
                     DIR_UP: begin
                        if (addr_ff[AW-1:SW] == '0) state_ff <= S_RESP;
                        else begin
                           addr_ff <= addr_ff - AW'(GRID_SIDE); state_ff <= S_PRD;
                        end
                     end
                     DIR_DOWN: begin
                        if (32'(addr_ff[AW-1:SW]) == GRID_SIDE - 1) state_ff <= S_RESP;
                        else begin
                           addr_ff <= addr_ff + AW'(GRID_SIDE); state_ff <= S_PRD;
                        end
                     end
                     DIR_LEFT: begin
                        if (addr_ff[SW-1:0] == '0) state_ff <= S_RESP;
                        else begin
                           addr_ff <= addr_ff - AW'(1); state_ff <= S_PRD;
                        end
                     end
                     default: begin
                        if (32'(addr_ff[SW-1:0]) == GRID_SIDE - 1) state_ff <= S_RESP;
                        else begin
                           addr_ff <= addr_ff + AW'(1); state_ff <= S_PRD;
                        end
                     end
                  endcase
               end
            end
            S_RESP: begin
               if (!rv_ff) rv_ff <= 1'b1;
               else if (rsp_ready) begin
                  rv_ff <= 1'b0; state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready      = state_ff == S_IDLE;
   assign rsp_valid      = rv_ff;
   assign rsp_status     = st_ff;
   assign rsp_out_row    = orow_ff;
   assign rsp_out_col    = ocol_ff;
   assign rsp_cell_label = olbl_ff;
endmodule
